### design/rwab_pkg.sv
// Shared constants, widths and types for the RSSI window averager.
`default_nettype none

package rwab_pkg;

  // Window depth and derived widths
  localparam int WINDOW   = 8;
  localparam int SAMPLE_W = 8;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int MC_W     = SAMPLE_W + CNT_W;
  localparam int D_W      = CNT_W + 10;
  localparam int DIFF_W   = ((SUM_W > MC_W) ? SUM_W : MC_W) + 1;
  localparam int N_W      = DIFF_W + 8;
  localparam int T_W      = D_W + 8;

  // Field widths of the ports
  localparam int THR_W      = 7;
  localparam int BAND_W     = 2;
  localparam int OUT_SUM_W  = 11;
  localparam int OUT_CNT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RSSI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RSSI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] MIN_RSSI_RST = 8'd162;
  localparam logic [SAMPLE_W-1:0] MAX_RSSI_RST = 8'd218;
  localparam logic [THR_W-1:0]    THR_LOW_RST  = 7'd28;
  localparam logic [THR_W-1:0]    THR_HIGH_RST = 7'd40;

  // Percent scale
  localparam logic signed [7:0] PCT_SCALE = 8'sd100;

  // Band codes
  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

  // Stage enables from the sequencer to the arithmetic
  typedef struct packed {
    logic mul_en;
    logic prod_en;
  } band_ctrl_t;

endpackage

`default_nettype wire

### design/rwab_cell.sv
// One cell of the sample shift chain: holds a sample, passes it on when shifting.
`default_nettype none

module rwab_cell (
  input  wire                          clk_i,
  input  wire                          shift_en_i,
  input  wire [rwab_pkg::SAMPLE_W-1:0] d_i,
  output logic [rwab_pkg::SAMPLE_W-1:0] q_o
);
  import rwab_pkg::*;

  logic [SAMPLE_W-1:0] sample_q;

  // Payload only, read after it has been written
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

`default_nettype wire

### design/rwab_window.sv
// Sliding window: chain of sample cells with running sum and fill count.
`default_nettype none

module rwab_window (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          shift_en_i,
  input  wire [rwab_pkg::SAMPLE_W-1:0] sample_i,
  output logic [rwab_pkg::SUM_W-1:0]   sum_o,
  output logic [rwab_pkg::CNT_W-1:0]   cnt_o
);
  import rwab_pkg::*;

  logic [SAMPLE_W-1:0] taps [0:WINDOW];
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                full;

  assign taps[0] = sample_i;

  // Newest sample enters at cell 0, oldest sits in the last cell
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    rwab_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en_i),
      .d_i        (taps[k]),
      .q_o        (taps[k+1])
    );
  end

  assign full = (cnt_q == CNT_W'(WINDOW));

  // Oldest sample drops out of the sum once the window is full
  always_comb begin
    sum_d = sum_q + SUM_W'(sample_i);
    cnt_d = cnt_q;
    if (full) begin
      sum_d = sum_q - SUM_W'(taps[WINDOW]) + SUM_W'(sample_i);
    end else begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (shift_en_i) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o = sum_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

### design/rwab_band.sv
// Band decision: cross-multiplied threshold compare in two product stages.
`default_nettype none

module rwab_band (
  input  wire                          clk_i,
  input  wire rwab_pkg::band_ctrl_t    ctrl_i,
  input  wire [rwab_pkg::SAMPLE_W-1:0] min_rssi_i,
  input  wire [rwab_pkg::SAMPLE_W-1:0] max_rssi_i,
  input  wire [rwab_pkg::THR_W-1:0]    thr_low_i,
  input  wire [rwab_pkg::THR_W-1:0]    thr_high_i,
  input  wire [rwab_pkg::SUM_W-1:0]    sum_i,
  input  wire [rwab_pkg::CNT_W-1:0]    cnt_i,
  output logic [rwab_pkg::BAND_W-1:0]  band_o
);
  import rwab_pkg::*;

  logic        [MC_W-1:0]   mc_q;
  logic signed [D_W-1:0]    d_q;
  logic signed [8:0]        span;
  logic signed [DIFF_W-1:0] diff;
  logic signed [N_W-1:0]    n_q;
  logic signed [T_W-1:0]    tl_q, th_q;
  logic                     d_zero_q, d_neg_q;
  logic                     below, above;

  assign span = $signed({1'b0, max_rssi_i}) - $signed({1'b0, min_rssi_i});
  assign diff = $signed(DIFF_W'(sum_i)) - $signed(DIFF_W'(mc_q));

  // Stage 1: min * count and the scaled span D = count * (max - min)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      mc_q <= MC_W'(min_rssi_i) * MC_W'(cnt_i);
      d_q  <= D_W'($signed({1'b0, cnt_i})) * D_W'(span);
    end
  end

  // Stage 2: N = (sum - min*count) * 100 and each threshold times D
  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      n_q      <= N_W'(diff) * N_W'(PCT_SCALE);
      tl_q     <= T_W'($signed({1'b0, thr_low_i})) * T_W'(d_q);
      th_q     <= T_W'($signed({1'b0, thr_high_i})) * T_W'(d_q);
      d_zero_q <= (d_q == '0);
      d_neg_q  <= d_q[D_W-1];
    end
  end

  // Negative D reverses both compares
  always_comb begin
    if (d_neg_q) begin
      below = (n_q > tl_q);
      above = (n_q < th_q);
    end else begin
      below = (n_q < tl_q);
      above = (n_q > th_q);
    end
  end

  // Zero D (span or count zero): band follows the sign of N; otherwise low test wins
  always_comb begin
    if (d_zero_q) begin
      if (n_q < 0) begin
        band_o = BAND_LOW;
      end else if (n_q > 0) begin
        band_o = BAND_HIGH;
      end else begin
        band_o = BAND_MID;
      end
    end else if (below) begin
      band_o = BAND_LOW;
    end else if (above) begin
      band_o = BAND_HIGH;
    end else begin
      band_o = BAND_MID;
    end
  end

endmodule

`default_nettype wire

### design/rssi_window_average_band_core.sv
// Top level of the RSSI window averager with threshold band output.
`default_nettype none

// Each accepted sample shifts into a chain of WINDOW cells, and the running
// sum and fill count update on the accept edge. The band is then found over
// two product stages (min*count and count*span, then the percent-scaled
// numerator against each threshold times the span) and is loaded into the
// output register from the done state once that register is free. A new
// sample is taken only after the accept, the two multiplier stages and the
// output load. The block works on one sample at a time; it
// takes the next sample while a finished result still waits at the output,
// and holds its last stage if the output register is still occupied when the
// next result completes.
// Configuration writes take effect at once and belong in idle periods.
module rssi_window_average_band_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [rwab_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [rwab_pkg::BAND_W-1:0]    band_o,
  output logic [rwab_pkg::OUT_SUM_W-1:0] window_sum_o,
  output logic [rwab_pkg::OUT_CNT_W-1:0] sample_count_o,
  input  wire                            cfg_we_i,
  input  wire [rwab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [rwab_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rwab_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROD,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [SAMPLE_W-1:0] min_rssi_q, max_rssi_q;
  logic [THR_W-1:0]    thr_low_q, thr_high_q;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    cnt;
  logic [BAND_W-1:0]   band;
  logic                in_fire;
  logic                out_free;
  band_ctrl_t          ctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rssi_q <= MIN_RSSI_RST;
      max_rssi_q <= MAX_RSSI_RST;
      thr_low_q  <= THR_LOW_RST;
      thr_high_q <= THR_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_RSSI: min_rssi_q <= cfg_data_i;
        REG_MAX_RSSI: max_rssi_q <= cfg_data_i;
        REG_THR_LOW:  thr_low_q  <= cfg_data_i[THR_W-1:0];
        REG_THR_HIGH: thr_high_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  assign ctrl.mul_en  = (state_q == ST_MUL);
  assign ctrl.prod_en = (state_q == ST_PROD);

  rwab_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (in_fire),
    .sample_i   (sample_i),
    .sum_o      (sum),
    .cnt_o      (cnt)
  );

  rwab_band u_band (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .min_rssi_i (min_rssi_q),
    .max_rssi_i (max_rssi_q),
    .thr_low_i  (thr_low_q),
    .thr_high_i (thr_high_q),
    .sum_i      (sum),
    .cnt_i      (cnt),
    .band_o     (band)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_o    <= 1'b0;
      band_o         <= BAND_LOW;
      window_sum_o   <= '0;
      sample_count_o <= '0;
    end else begin
      // Load a finished result when free, else drop a result once taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_o    <= 1'b1;
        band_o         <= band;
        window_sum_o   <= OUT_SUM_W'(sum);
        sample_count_o <= OUT_CNT_W'(cnt);
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:  state_q <= ST_PROD;
        ST_PROD: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // One sample in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("sample accepted while another is in flight");

  // Fill count never passes the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CNT_W'(WINDOW))
    else $error("fill count beyond window depth");

  // A delivered result always carries a defined band code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (band_o == BAND_LOW || band_o == BAND_MID || band_o == BAND_HIGH))
    else $error("undefined band code at output");

  // Output loads only when the register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (state_q != ST_IDLE || $past(state_q) != ST_DONE))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
